@@ rtl/ts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pkg
// Shared types and constants for the Taylor-series sine pipeline.
// ----------------------------------------------------------------------------
package ts_pkg;

    localparam logic signed [33:0] PI_Q24     = 34'sd52707179;
    localparam logic signed [33:0] TWO_PI_Q24 = 34'sd105414357;
    localparam int                 FRAC_SHIFT = 30;
    localparam int                 RECIP_SHIFT = 37;   // p < 2^37, so q0 is q or q-1
    localparam int                 RED_STEPS  = 5;     // up to 31 multiples of 2*pi
    localparam logic [30:0]        THRESH_RESET = 31'd1074;

    // item state carried between term stages
    typedef struct packed {
        logic               valid;
        logic               neg;     // sign of reduced angle
        logic [33:0]        x2;      // x^2, Q.30
        logic [32:0]        term;    // last term magnitude, Q.30
        logic signed [35:0] sum;     // running sum, Q.30
        logic [4:0]         count;   // terms summed
        logic               done;    // threshold reached
        logic               limit;   // term limit reached first
    } t_item;

endpackage

@@ rtl/ts_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_reduce
// Range reduction into [-pi, pi], one binary multiple of 2*pi per stage.
// ----------------------------------------------------------------------------
module ts_reduce (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [31:0]  i_angle,
    output logic                o_valid,
    output logic signed [33:0]  o_x
);

    logic               r_valid [ts_pkg::RED_STEPS+1];
    logic signed [33:0] r_x     [ts_pkg::RED_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0] <= 34'(i_angle);
        end
    end

    // greedy: take 2^b steps when at least 2^b are still needed
    for (genvar j = 0; j < ts_pkg::RED_STEPS; j++) begin : g_step
        localparam int B = ts_pkg::RED_STEPS - 1 - j;
        localparam logic signed [33:0] STEP = 34'(ts_pkg::TWO_PI_Q24 <<< B);
        logic signed [33:0] sub_x;
        logic signed [33:0] add_x;
        logic signed [33:0] n_x;

        always_comb begin
            sub_x = r_x[j] - STEP;
            add_x = r_x[j] + STEP;
            if (sub_x > ts_pkg::PI_Q24 - ts_pkg::TWO_PI_Q24) begin
                n_x = sub_x;
            end else if (add_x < ts_pkg::TWO_PI_Q24 - ts_pkg::PI_Q24) begin
                n_x = add_x;
            end else begin
                n_x = r_x[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= r_valid[j];
            end
            if (i_en) begin
                r_x[j+1] <= n_x;
            end
        end
    end

    assign o_valid = r_valid[ts_pkg::RED_STEPS];
    assign o_x     = r_x[ts_pkg::RED_STEPS];

endmodule

@@ rtl/ts_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_prep
// Magnitude to Q.30, x^2, and the first series term.
// ----------------------------------------------------------------------------
module ts_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [33:0]  i_x,
    input  logic [30:0]         i_thresh,
    output ts_pkg::t_item       o_item
);

    logic        r_valid1;
    logic        r_neg1;
    logic [31:0] r_mag1;
    logic [33:0] abs_x;
    logic [63:0] sq;
    ts_pkg::t_item r_item;
    ts_pkg::t_item n_item;

    assign abs_x = i_x[33] ? -i_x : i_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
        end
        if (i_en) begin
            r_neg1 <= i_x[33];
            r_mag1 <= {abs_x[25:0], 6'b0};
        end
    end

    always_comb begin
        sq             = 64'(r_mag1) * 64'(r_mag1);
        n_item.valid   = r_valid1;
        n_item.neg     = r_neg1;
        n_item.x2      = 34'(sq >> ts_pkg::FRAC_SHIFT);
        n_item.term    = 33'(r_mag1);
        n_item.sum     = r_neg1 ? -36'sd0 - $signed(36'(r_mag1)) : $signed(36'(r_mag1));
        n_item.count   = 5'd1;
        n_item.done    = 33'(r_mag1) <= 33'(i_thresh);
        n_item.limit   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item.valid <= n_item.valid;
        end
        if (i_en) begin
            r_item.neg   <= n_item.neg;
            r_item.x2    <= n_item.x2;
            r_item.term  <= n_item.term;
            r_item.sum   <= n_item.sum;
            r_item.count <= n_item.count;
            r_item.done  <= n_item.done;
            r_item.limit <= n_item.limit;
        end
    end

    assign o_item = r_item;

endmodule

@@ rtl/ts_term.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_term
// One series term: multiply by x^2, divide by (2n)(2n+1), accumulate.
// ----------------------------------------------------------------------------
module ts_term #(
    parameter int N         = 1,
    parameter int MAX_TERMS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [30:0]   i_thresh,
    input  ts_pkg::t_item i_item,
    output ts_pkg::t_item o_item
);

    localparam longint unsigned D = longint'(2 * N * (2 * N + 1));
    localparam logic [34:0] R = 35'((64'd1 << ts_pkg::RECIP_SHIFT) / D);

    ts_pkg::t_item r_a;
    ts_pkg::t_item r_b;
    ts_pkg::t_item r_c;
    logic [36:0]   r_p_a;
    logic [36:0]   r_p_b;
    logic [34:0]   r_q0_b;
    logic [66:0]   prod_a;
    logic [71:0]   prod_b;
    logic [43:0]   rem;
    logic [34:0]   quo;
    logic [32:0]   new_term;
    logic signed [35:0] term_s;
    logic          hit;
    ts_pkg::t_item n_c;

    // stage A: term * x^2
    assign prod_a = 67'(i_item.term) * 67'(i_item.x2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (i_en) begin
            r_a.valid <= i_item.valid;
        end
        if (i_en) begin
            r_a.neg   <= i_item.neg;
            r_a.x2    <= i_item.x2;
            r_a.term  <= i_item.term;
            r_a.sum   <= i_item.sum;
            r_a.count <= i_item.count;
            r_a.done  <= i_item.done;
            r_a.limit <= i_item.limit;
            r_p_a     <= 37'(prod_a >> ts_pkg::FRAC_SHIFT);
        end
    end

    // stage B: reciprocal estimate, low by at most one
    assign prod_b = 72'(r_p_a) * 72'(R);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_b.valid <= r_a.valid;
        end
        if (i_en) begin
            r_b.neg   <= r_a.neg;
            r_b.x2    <= r_a.x2;
            r_b.term  <= r_a.term;
            r_b.sum   <= r_a.sum;
            r_b.count <= r_a.count;
            r_b.done  <= r_a.done;
            r_b.limit <= r_a.limit;
            r_p_b     <= r_p_a;
            r_q0_b    <= 35'(prod_b >> ts_pkg::RECIP_SHIFT);
        end
    end

    // stage C: correct quotient, accumulate, test threshold
    always_comb begin
        rem      = 44'(r_p_b) - 44'(r_q0_b) * 44'(D);
        quo      = (rem >= 44'(D)) ? r_q0_b + 35'd1 : r_q0_b;
        new_term = quo[32:0];
        term_s   = $signed(36'(new_term));
        hit      = new_term <= 33'(i_thresh);
        n_c      = r_b;
        if (!r_b.done) begin
            n_c.term  = new_term;
            n_c.sum   = (r_b.neg ^ N[0]) ? r_b.sum - term_s : r_b.sum + term_s;
            n_c.count = 5'(N + 1);
            n_c.done  = hit;
            n_c.limit = (N + 1 == MAX_TERMS) && !hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else if (i_en) begin
            r_c.valid <= n_c.valid;
        end
        if (i_en) begin
            r_c.neg   <= n_c.neg;
            r_c.x2    <= n_c.x2;
            r_c.term  <= n_c.term;
            r_c.sum   <= n_c.sum;
            r_c.count <= n_c.count;
            r_c.done  <= n_c.done;
            r_c.limit <= n_c.limit;
        end
    end

    assign o_item = r_c;

endmodule

@@ rtl/taylor_sine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine
// Fixed-point sine of a Q8.24 angle by Taylor series, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                        | payload
//  ----------+-----------+----------------------------------+---------------------------
//  angle     | in        | i_angle_valid / o_angle_ready    | i_angle
//  result    | out       | o_result_valid / i_result_ready  | o_sine_value, o_terms_used,
//            |           |                                  | o_limit_hit
//  config    | in        | i_cfg_wr_en (no wait)            | i_cfg_wr_data
//
//  One transfer can enter every cycle unless the output stalls. Each angle passes the
//  input register and reduction stages, the prep registers, stages A, B and C of each
//  extra term unit (MAX_TERMS-1 term units) and one output register.
//  Each term unit holds one 33x34 multiply, one reciprocal multiply for the
//  constant divide, and a correction/accumulate stage.
//  The whole pipeline stalls as one when the output register is full and not
//  taken; nothing is dropped or repeated. Synchronous active-low reset clears
//  valid bits and loads the threshold with its default.
// ----------------------------------------------------------------------------
module taylor_sine #(
    parameter int MAX_TERMS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_angle_valid,
    output logic                o_angle_ready,
    input  logic signed [31:0]  i_angle,
    output logic                o_result_valid,
    input  logic                i_result_ready,
    output logic signed [31:0]  o_sine_value,
    output logic [3:0]          o_terms_used,
    output logic                o_limit_hit,
    input  logic                i_cfg_wr_en,
    input  logic [30:0]         i_cfg_wr_data
);

    logic [30:0]        r_stop_threshold;
    logic               en;
    logic               red_valid;
    logic signed [33:0] red_x;
    ts_pkg::t_item      item [MAX_TERMS];
    ts_pkg::t_item      last;

    logic               r_out_valid;
    logic signed [31:0] r_sine;
    logic [3:0]         r_terms;
    logic               r_limit;
    logic signed [31:0] n_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_threshold <= ts_pkg::THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_stop_threshold <= i_cfg_wr_data;
        end
    end

    // single stall for the whole pipe
    assign en            = !r_out_valid || i_result_ready;
    assign o_angle_ready = en;

    ts_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_angle_valid),
        .i_angle (i_angle),
        .o_valid (red_valid),
        .o_x     (red_x)
    );

    ts_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (red_valid),
        .i_x      (red_x),
        .i_thresh (r_stop_threshold),
        .o_item   (item[0])
    );

    for (genvar n = 1; n < MAX_TERMS; n++) begin : g_term
        ts_term #(
            .N         (n),
            .MAX_TERMS (MAX_TERMS)
        ) u_term (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_thresh (r_stop_threshold),
            .i_item   (item[n-1]),
            .o_item   (item[n])
        );
    end

    assign last = item[MAX_TERMS-1];

    // saturate to Q2.30
    always_comb begin
        if (last.sum > 36'sd2147483647) begin
            n_sine = 32'sh7FFFFFFF;
        end else if (last.sum < -36'sd2147483648) begin
            n_sine = 32'sh80000000;
        end else begin
            n_sine = last.sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
        if (en) begin
            r_sine  <= n_sine;
            r_terms <= last.count[3:0];
            r_limit <= last.limit;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_sine_value   = r_sine;
    assign o_terms_used   = r_terms;
    assign o_limit_hit    = r_limit;

endmodule

@@ rtl/ts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_checker
// Port-level checks for taylor_sine, bound to the top level.
// ----------------------------------------------------------------------------
module ts_checker #(
    parameter int MAX_TERMS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_angle_ready,
    input  logic               o_result_valid,
    input  logic               i_result_ready,
    input  logic signed [31:0] o_sine_value,
    input  logic [3:0]         o_terms_used,
    input  logic               o_limit_hit
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_limit_hit |-> o_terms_used == 4'(MAX_TERMS))
        else $error("limit flag without full term count");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |-> !o_angle_ready)
        else $error("input taken while output stalled");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=> o_result_valid && $stable(o_sine_value))
        else $error("stalled result changed");

endmodule

bind taylor_sine ts_checker #(.MAX_TERMS(MAX_TERMS)) u_ts_checker (.*);
